FILE: hdl/ats_pkg.sv
// ATS parser package: sequencer states, constants, FSC decoding, index clamping and the time-scaling helper.
package ats_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_APPLY,
		ST_DONE
	} state_t;

	localparam logic        REG_CARRIER  = 1'b0;
	localparam logic        REG_TYPE_A   = 1'b1;

	localparam logic [24:0] CARRIER_RST  = 25'd13560000;
	localparam logic [31:0] DIVIDEND     = 32'd4096000000;
	localparam logic [3:0]  INDEX_MAX    = 4'd14;
	localparam logic [3:0]  FWI_DEFAULT  = 4'd4;
	localparam logic [3:0]  SFGI_DEFAULT = 4'd0;
	localparam logic [8:0]  FSC_DEFAULT  = 9'd32;
	localparam logic [7:0]  TA_DEFAULT   = 8'h80;
	localparam logic [26:0] TIME_MAX     = 27'h7FFFFFF;

	function automatic logic [8:0] fsc_decode(input logic [3:0] fsci);
		logic [8:0] fsc;
		unique case (fsci)
			4'd0:    fsc = 9'd16;
			4'd1:    fsc = 9'd24;
			4'd2:    fsc = 9'd32;
			4'd3:    fsc = 9'd40;
			4'd4:    fsc = 9'd48;
			4'd5:    fsc = 9'd64;
			4'd6:    fsc = 9'd96;
			4'd7:    fsc = 9'd128;
			default: fsc = 9'd256;
		endcase
		return fsc;
	endfunction

	function automatic logic [3:0] clamp_index(input logic [3:0] x);
		return (x > INDEX_MAX) ? INDEX_MAX : x;
	endfunction

	function automatic logic [26:0] scale_us(input logic [31:0] q, input logic [3:0] x);
		logic [45:0] wide;
		wide = {14'd0, q} << x;
		return (|wide[45:27]) ? TIME_MAX : wide[26:0];
	endfunction

endpackage

FILE: hdl/ats_answer_parser_top.sv
// ATS parser top level: byte sequencer, bit-serial divider and result register.
// Bytes are taken in the idle state. A TB byte, or the end of a one-byte ATS,
// starts the bit-serial division of 4096000000 by the carrier; the quotient
// then scales the guard and wait times. A frame's last byte loads the result
// register. Item input stalls during a division and until that load is done.
// Reset: asynchronous, active low; clears stores, carrier 13560000, type A set.
module ats_answer_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [24:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  ats_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        status,
	output logic [8:0]  frame_size,
	output logic [7:0]  ta_value,
	output logic [26:0] guard_time_us,
	output logic [26:0] wait_time_us,
	output logic        nad_supported,
	output logic        cid_supported,
	output logic [7:0]  hist_offset,
	output logic [7:0]  hist_len
);

	ats_pkg::state_t state_q, state_next;

	logic [24:0] carrier_q;
	logic        type_a_q;
	logic [7:0]  pos_q;
	logic [7:0]  flen_q;
	logic [7:0]  fmt_q;
	logic [7:0]  ta_q;
	logic [8:0]  fsc_q;
	logic [26:0] guard_q;
	logic [26:0] wait_q;
	logic        nad_q;
	logic        cid_q;

	logic        end_q;
	logic        err_q;
	logic [7:0]  cur_q;
	logic [7:0]  hlen_q;
	logic [3:0]  sfgi_q;
	logic [3:0]  fwi_q;
	logic        wr_wait_q;

	logic [4:0]  cnt_q;
	logic [25:0] rem_q;
	logic [31:0] quo_q;

	logic        accept;
	logic        out_free;
	logic        ha, hb, hc;
	logic        taken;
	logic        hit_tb;
	logic [7:0]  flen_new;
	logic [7:0]  fmt_new;
	logic [8:0]  size;
	logic [7:0]  len;
	logic        one;
	logic        need_div;
	logic [7:0]  cur_new;
	logic [25:0] trial;
	logic        ge;

	assign cfg_ready = 1'b1;
	assign accept    = item_valid & ~item_stall;
	assign out_free  = ~result_valid | ~result_stall;

	assign ha    = fmt_q[4];
	assign hb    = fmt_q[5];
	assign hc    = fmt_q[6];
	assign taken = (pos_q != 8'd0) && (flen_q >= 8'd2);
	assign hit_tb = taken && (pos_q != 8'd1) && !(ha && pos_q == 8'd2)
		&& hb && (pos_q == 8'd2 + {7'd0, ha});

	assign flen_new = (pos_q == 8'd0) ? ats_byte : flen_q;
	assign fmt_new  = (taken && pos_q == 8'd1) ? ats_byte : fmt_q;
	assign size     = {1'b0, pos_q} + 9'd1;
	assign len      = ({1'b0, flen_new} < size) ? flen_new : size[7:0];
	assign one      = (flen_new != 8'd0) && (len == 8'd1);
	assign cur_new  = one ? 8'd1 : 8'd2 + {7'd0, fmt_new[4]} + {7'd0, fmt_new[5]}
		+ {7'd0, fmt_new[6]};
	assign need_div = hit_tb || (last_byte && one);

	assign trial = {rem_q[24:0], ats_pkg::DIVIDEND[5'd31 - cnt_q]};
	assign ge    = trial >= {1'b0, carrier_q};

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ats_pkg::ST_IDLE: begin
				if (accept) begin
					if (need_div) state_next = ats_pkg::ST_DIV;
					else if (last_byte) state_next = ats_pkg::ST_DONE;
				end
			end
			ats_pkg::ST_DIV: begin
				if (cnt_q == 5'd31) state_next = ats_pkg::ST_APPLY;
			end
			ats_pkg::ST_APPLY: begin
				state_next = end_q ? ats_pkg::ST_DONE : ats_pkg::ST_IDLE;
			end
			ats_pkg::ST_DONE: begin
				if (out_free) state_next = ats_pkg::ST_IDLE;
			end
			default: state_next = ats_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall = (state_q != ats_pkg::ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ats_pkg::ST_IDLE;
			carrier_q <= ats_pkg::CARRIER_RST;
			type_a_q  <= 1'b1;
			pos_q     <= 8'd0;
			flen_q    <= 8'd0;
			fmt_q     <= 8'd0;
			ta_q      <= 8'd0;
			fsc_q     <= 9'd0;
			guard_q   <= 27'd0;
			wait_q    <= 27'd0;
			nad_q     <= 1'b0;
			cid_q     <= 1'b0;
			end_q     <= 1'b0;
			err_q     <= 1'b0;
			cur_q     <= 8'd0;
			hlen_q    <= 8'd0;
			sfgi_q    <= 4'd0;
			fwi_q     <= 4'd0;
			wr_wait_q <= 1'b0;
			cnt_q     <= 5'd0;
			rem_q     <= 26'd0;
			quo_q     <= 32'd0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_next;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					ats_pkg::REG_CARRIER: carrier_q <= cfg_data;
					ats_pkg::REG_TYPE_A:  type_a_q  <= cfg_data[0];
					default: ;
				endcase
			end

			if (accept) begin
				if (pos_q == 8'd0) begin
					flen_q <= ats_byte;
				end else if (taken) begin
					if (pos_q == 8'd1) begin
						fmt_q <= ats_byte;
						fsc_q <= ats_pkg::fsc_decode(ats_byte[3:0]);
						ta_q  <= 8'd0;
					end else if (ha && pos_q == 8'd2) begin
						ta_q <= ats_byte;
					end else if (hit_tb) begin
						sfgi_q    <= ats_pkg::clamp_index(ats_byte[3:0]);
						fwi_q     <= ats_pkg::clamp_index(ats_byte[7:4]);
						wr_wait_q <= 1'b1;
					end else if (hc && pos_q == 8'd2 + {7'd0, ha} + {7'd0, hb}) begin
						if (ats_byte[0]) nad_q <= 1'b1;
						if (ats_byte[1]) cid_q <= 1'b1;
					end
				end

				if (last_byte) pos_q <= 8'd0;
				else if (pos_q != 8'd255) pos_q <= pos_q + 8'd1;

				end_q <= last_byte;
				if (last_byte) begin
					err_q  <= (flen_new == 8'd0);
					cur_q  <= cur_new;
					hlen_q <= (len > cur_new) ? len - cur_new : 8'd0;
					if (one) begin
						fsc_q     <= ats_pkg::FSC_DEFAULT;
						ta_q      <= ats_pkg::TA_DEFAULT;
						sfgi_q    <= ats_pkg::SFGI_DEFAULT;
						fwi_q     <= ats_pkg::FWI_DEFAULT;
						wr_wait_q <= type_a_q;
					end
				end
				cnt_q <= 5'd0;
				rem_q <= 26'd0;
			end

			if (state_q == ats_pkg::ST_DIV) begin
				cnt_q <= cnt_q + 5'd1;
				rem_q <= ge ? trial - {1'b0, carrier_q} : trial;
				quo_q <= {quo_q[30:0], ge};
			end

			if (state_q == ats_pkg::ST_APPLY) begin
				guard_q <= ats_pkg::scale_us(quo_q, sfgi_q);
				if (wr_wait_q) wait_q <= ats_pkg::scale_us(quo_q, fwi_q);
			end

			if (state_q == ats_pkg::ST_DONE && out_free) begin
				result_valid <= 1'b1;
			end else if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ats_pkg::ST_DONE && out_free) begin
			status        <= err_q;
			frame_size    <= err_q ? 9'd0  : fsc_q;
			ta_value      <= err_q ? 8'd0  : ta_q;
			guard_time_us <= err_q ? 27'd0 : guard_q;
			wait_time_us  <= err_q ? 27'd0 : wait_q;
			nad_supported <= ~err_q & nad_q;
			cid_supported <= ~err_q & cid_q;
			hist_offset   <= err_q ? 8'd0  : cur_q;
			hist_len      <= err_q ? 8'd0  : hlen_q;
		end
	end

endmodule
